// File: src/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants for the 8-bit ALU with flags
// Operation codes, field widths, flag bit positions and decimal-adjust constants.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int OP_W   = 6;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int FLAG_W = 4;
  localparam int BIT_W  = 3;

  // Flag bit positions within the packed flags nibble.
  localparam int FZ = 3;
  localparam int FN = 2;
  localparam int FH = 1;
  localparam int FC = 0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 6'd0,
    OP_ADC   = 6'd1,
    OP_SUB   = 6'd2,
    OP_SBC   = 6'd3,
    OP_AND   = 6'd4,
    OP_XOR   = 6'd5,
    OP_OR    = 6'd6,
    OP_CP    = 6'd7,
    OP_INC8  = 6'd8,
    OP_DEC8  = 6'd9,
    OP_DAA   = 6'd10,
    OP_CPL   = 6'd11,
    OP_CCF   = 6'd12,
    OP_SCF   = 6'd13,
    OP_RLC   = 6'd14,
    OP_RRC   = 6'd15,
    OP_RL    = 6'd16,
    OP_RR    = 6'd17,
    OP_SLA   = 6'd18,
    OP_SRA   = 6'd19,
    OP_SWAP  = 6'd20,
    OP_SRL   = 6'd21,
    OP_BIT   = 6'd22,
    OP_RES   = 6'd23,
    OP_SET   = 6'd24,
    OP_RLCA  = 6'd25,
    OP_RRCA  = 6'd26,
    OP_RLA   = 6'd27,
    OP_RRA   = 6'd28,
    OP_ADD16 = 6'd29,
    OP_ADDSP = 6'd30,
    OP_INC16 = 6'd31,
    OP_DEC16 = 6'd32
  } opcode_t;

  localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
  localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0]        DAA_LO_LIM = 4'd9;

endpackage

// File: src/cpu_alu_with_flags_top.sv
// Each item passes through the input register, then the result register;
// out_valid rises when the item is loaded into the result register.
// Throughput: one item per cycle while out_stall is low; the result register
// frees as it is taken, so a new item enters every cycle unless the output stalls.
// Reset (rst_n low, synchronous) empties both stages; payload registers
// are not reset.
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_top: 8-bit CPU ALU with Z/N/H/C flags
// Byte arithmetic, logic, rotates, bit ops, decimal adjust and 16-bit add,
// increment and decrement, computed between an input register and a result register.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [caf_pkg::OP_W-1:0]    in_opcode,
  input  logic [caf_pkg::BYTE_W-1:0]  in_acc_value,
  input  logic [caf_pkg::BYTE_W-1:0]  in_byte_operand,
  input  logic [caf_pkg::BIT_W-1:0]   in_bit_index,
  input  logic [caf_pkg::FLAG_W-1:0]  in_flags_in,
  input  logic [caf_pkg::WORD_W-1:0]  in_word_target,
  input  logic [caf_pkg::WORD_W-1:0]  in_word_operand,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [caf_pkg::BYTE_W-1:0]  out_byte_result,
  output logic [caf_pkg::WORD_W-1:0]  out_word_result,
  output logic [caf_pkg::FLAG_W-1:0]  out_flags_out,
  output logic                        out_writes_back
);
  import caf_pkg::*;

  // Input stage.
  logic              s1_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] a_r;
  logic [BYTE_W-1:0] v_r;
  logic [BIT_W-1:0]  bi_r;
  logic [FLAG_W-1:0] f_r;
  logic [WORD_W-1:0] wt_r;
  logic [WORD_W-1:0] wo_r;

  // Result stage.
  logic              out_valid_r;
  logic [BYTE_W-1:0] br_r;
  logic [WORD_W-1:0] wr_r;
  logic [FLAG_W-1:0] fo_r;
  logic              wb_r;

  logic              s2_free;
  logic              s1_free;
  logic              s1_adv;
  logic              in_fire;

  logic [BYTE_W-1:0] br_nxt;
  logic [WORD_W-1:0] wr_nxt;
  logic [FLAG_W-1:0] fo_nxt;
  logic              wb_nxt;

  assign s2_free  = ~out_valid_r | ~out_stall;
  assign s1_adv   = s1_valid_r & s2_free;
  assign s1_free  = ~s1_valid_r | s2_free;
  assign in_stall = ~s1_free;
  assign in_fire  = in_valid & s1_free;

  // ---------------------------------------------------------------- datapath
  logic              c_in;
  logic              z_res;
  logic [8:0]        sum9;
  logic [4:0]        sum5;
  logic [8:0]        dif9;
  logic [4:0]        dif5;
  logic              ci;
  logic              daa_lo;
  logic              daa_hi;
  logic [BYTE_W-1:0] daa_corr;
  logic [BYTE_W-1:0] sx;
  logic              sco;
  logic              rot_acc;
  logic [16:0]       sum17;
  logic [12:0]       sum13;
  logic [WORD_W-1:0] sp_off;
  logic [WORD_W-1:0] sp_sum;
  logic [WORD_W-1:0] sp_x;

  always_comb begin
    c_in   = f_r[FC];
    ci     = ((op_r == OP_ADC) || (op_r == OP_SBC)) ? c_in : 1'b0;
    sum9   = {1'b0, a_r} + {1'b0, v_r} + {8'd0, ci};
    sum5   = {1'b0, a_r[3:0]} + {1'b0, v_r[3:0]} + {4'd0, ci};
    // Bit 8 / bit 4 of the difference is the borrow out.
    dif9   = {1'b0, a_r} - {1'b0, v_r} - {8'd0, ci};
    dif5   = {1'b0, a_r[3:0]} - {1'b0, v_r[3:0]} - {4'd0, ci};

    daa_lo   = f_r[FH] | (~f_r[FN] & (a_r[3:0] > DAA_LO_LIM));
    daa_hi   = c_in | (~f_r[FN] & (a_r > DAA_HI_LIM));
    daa_corr = (daa_lo ? DAA_LO_ADJ : 8'h00) | (daa_hi ? DAA_HI_ADJ : 8'h00);

    rot_acc = (op_r >= OP_RLCA);
    sx      = rot_acc ? a_r : v_r;

    sum17  = {1'b0, wt_r} + {1'b0, wo_r};
    sum13  = {1'b0, wt_r[11:0]} + {1'b0, wo_r[11:0]};
    sp_off = {{(WORD_W-BYTE_W){v_r[BYTE_W-1]}}, v_r};
    sp_sum = wt_r + sp_off;
    sp_x   = wt_r ^ sp_off ^ sp_sum;

    br_nxt = '0;
    wr_nxt = '0;
    fo_nxt = f_r;
    wb_nxt = 1'b1;
    sco    = 1'b0;

    case (op_r)
      OP_ADD, OP_ADC: begin
        br_nxt = sum9[7:0];
        fo_nxt = {1'b0, 1'b0, sum5[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        br_nxt = dif9[7:0];
        fo_nxt = {1'b0, 1'b1, dif5[4], dif9[8]};
        wb_nxt = (op_r != OP_CP);
      end
      OP_AND: begin
        br_nxt = a_r & v_r;
        fo_nxt = 4'b0010;
      end
      OP_XOR: begin
        br_nxt = a_r ^ v_r;
        fo_nxt = 4'b0000;
      end
      OP_OR: begin
        br_nxt = a_r | v_r;
        fo_nxt = 4'b0000;
      end
      OP_INC8: begin
        br_nxt = v_r + 8'd1;
        fo_nxt = {1'b0, 1'b0, (br_nxt[3:0] == 4'h0), c_in};
      end
      OP_DEC8: begin
        br_nxt = v_r - 8'd1;
        fo_nxt = {1'b0, 1'b1, (br_nxt[3:0] == 4'hF), c_in};
      end
      OP_DAA: begin
        br_nxt = f_r[FN] ? (a_r - daa_corr) : (a_r + daa_corr);
        fo_nxt = {1'b0, f_r[FN], 1'b0, c_in | daa_hi};
      end
      OP_CPL: begin
        br_nxt = ~a_r;
        fo_nxt = {f_r[FZ], 1'b1, 1'b1, c_in};
      end
      OP_CCF: begin
        fo_nxt = {f_r[FZ], 1'b0, 1'b0, ~c_in};
        wb_nxt = 1'b0;
      end
      OP_SCF: begin
        fo_nxt = {f_r[FZ], 1'b0, 1'b0, 1'b1};
        wb_nxt = 1'b0;
      end
      OP_RLC, OP_RLCA: begin
        sco    = sx[7];
        br_nxt = {sx[6:0], sx[7]};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_RRC, OP_RRCA: begin
        sco    = sx[0];
        br_nxt = {sx[0], sx[7:1]};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_RL, OP_RLA: begin
        sco    = sx[7];
        br_nxt = {sx[6:0], c_in};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_RR, OP_RRA: begin
        sco    = sx[0];
        br_nxt = {c_in, sx[7:1]};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_SLA: begin
        sco    = sx[7];
        br_nxt = {sx[6:0], 1'b0};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_SRA: begin
        sco    = sx[0];
        br_nxt = {sx[7], sx[7:1]};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_SWAP: begin
        br_nxt = {sx[3:0], sx[7:4]};
        fo_nxt = 4'b0000;
      end
      OP_SRL: begin
        sco    = sx[0];
        br_nxt = {1'b0, sx[7:1]};
        fo_nxt = {1'b0, 1'b0, 1'b0, sco};
      end
      OP_BIT: begin
        fo_nxt = {~v_r[bi_r], 1'b0, 1'b1, c_in};
        wb_nxt = 1'b0;
      end
      OP_RES: begin
        br_nxt = v_r;
        br_nxt[bi_r] = 1'b0;
      end
      OP_SET: begin
        br_nxt = v_r;
        br_nxt[bi_r] = 1'b1;
      end
      OP_ADD16: begin
        wr_nxt = sum17[WORD_W-1:0];
        fo_nxt = {f_r[FZ], 1'b0, sum13[12], sum17[16]};
      end
      OP_ADDSP: begin
        wr_nxt = sp_sum;
        fo_nxt = {1'b0, 1'b0, sp_x[4], sp_x[8]};
      end
      OP_INC16: wr_nxt = wt_r + 16'd1;
      OP_DEC16: wr_nxt = wt_r - 16'd1;
      default:  wb_nxt = 1'b0;
    endcase

    // Byte ops that own Z take it from the result; accumulator rotates clear it.
    z_res = (br_nxt == '0);
    if ((op_r <= OP_DAA) || ((op_r >= OP_RLC) && (op_r <= OP_SRL))) begin
      fo_nxt[FZ] = z_res;
    end
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_opcode;
      a_r  <= in_acc_value;
      v_r  <= in_byte_operand;
      bi_r <= in_bit_index;
      f_r  <= in_flags_in;
      wt_r <= in_word_target;
      wo_r <= in_word_operand;
    end
    if (s1_adv) begin
      br_r <= br_nxt;
      wr_r <= wr_nxt;
      fo_r <= fo_nxt;
      wb_r <= wb_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_result = br_r;
  assign out_word_result = wr_r;
  assign out_flags_out   = fo_r;
  assign out_writes_back = wb_r;

  // ------------------------------------------------------------ assertions
  a_adv_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("item leaving the input stage did not reach the result register");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> (s1_valid_r && $stable(op_r) && $stable(a_r)))
    else $error("item in the input stage was lost while the output was stalled");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((br_r == '0) || (wr_r == '0)))
    else $error("byte and word results both nonzero");

  a_accept_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !out_valid_r) |-> !in_stall)
    else $error("input stalled although the result register is empty");

endmodule
